// ===== rtl/core/rog_pkg.sv =====
// Shared types and constants for the rectangle occupancy grid.
// Item structs, op and status codes, register indexes and divider handshake types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rog_pkg;

    localparam int DIV_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_UNIT = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CHIP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP_HEIGHT = 1'b1;

    localparam logic [31:0] CHIP_W_RESET = 32'd262144;
    localparam logic [31:0] CHIP_H_RESET = 32'd196608;

    // floor(x / 10) == (x * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] rect_x;
        logic signed [31:0] rect_y;
        logic [30:0]        rect_width;
        logic [30:0]        rect_height;
        logic [15:0]        grid_col;
        logic [15:0]        grid_row;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        occupied;
        logic [31:0] cell_x;
        logic [31:0] cell_y;
        logic [31:0] unit_length;
        logic [15:0] grid_columns;
        logic [15:0] grid_rows;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/rog_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses rog_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module rog_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rog_pkg::t_div_req i_req,
    output rog_pkg::t_div_rsp o_rsp
);

    localparam int W     = rog_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic [W-1:0]     r_q;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]   rem_sh;
    logic         ge;
    logic [W-1:0] n_rem;

    assign rem_sh = {r_rem, r_q[W-1]};
    assign ge     = (rem_sh >= {1'b0, r_d});
    assign n_rem  = ge ? W'(rem_sh - {1'b0, r_d}) : W'(rem_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_d   <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/rect_occupancy_grid.sv =====
// Rectangle occupancy grid: rectangle store, grid sizing and point query.
// Depends on rog_pkg (types, codes) and rog_div (grid count dividers).
//
// Usage:
//   Config channel (i_cfg_*) writes chip width (index 0) or chip height
//   (index 1); always ready. Write only while the block is idle (not enforced).
//   Input channel takes one op per transfer: clear, add rectangle or query.
//   Output channel returns exactly one result per op.
// Sequencing:
//   One item in flight. When a grid unit exists, the result waits on the
//   32-step serial dividers that size the grid; they are skipped when there
//   is none (empty store, as after clear, or a unit truncated to 0). A query
//   that passes its checks then scans the store, one entry per cycle; a hit
//   on entry k (from 0) stops the scan early. The next transfer is taken in
//   the cycle after the result loads.
// Reset:
//   Synchronous, active low. Store empty, smallest side all ones, chip size
//   back to 4.0 x 3.0 mm. Store contents are not cleared: entries at and
//   above the count are never read. No clearing pass.
// Stall:
//   A finished result sits in the output register; the next op can be taken
//   meanwhile, and its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module rect_occupancy_grid #(
    parameter int MAX_RECTS       = 128,
    parameter int GRID_INDEX_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rog_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rog_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rog_pkg::t_out_item                  o_out_data
);

    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int GW    = (GRID_INDEX_BITS < 16) ? GRID_INDEX_BITS : 16;
    localparam logic [31:0]      GRID_CAP = 32'((64'd1 << GW) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RECTS);
    localparam int DIV10_SHIFT_L = rog_pkg::DIV10_SHIFT;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UNIT  = 3'd1;
    localparam logic [2:0] S_DIVST = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [31:0]        r_chip_w, r_chip_h;
    logic [CNT_W-1:0]   r_count;
    logic [31:0]        r_small;
    rog_pkg::t_in_item  r_in;
    logic [1:0]         r_status;
    logic [63:0]        r_prod;
    logic [31:0]        r_unit;
    logic [GW-1:0]      r_cols, r_rows;
    logic [47:0]        r_px, r_py;
    logic [CNT_W-1:0]   r_addr;
    logic               r_rd_vld;
    logic [63:0]        r_lo, r_up;
    logic               r_occ;
    logic               r_out_valid;
    rog_pkg::t_out_item r_out;

    logic [63:0] mem_lo [MAX_RECTS];
    logic [63:0] mem_up [MAX_RECTS];

    rog_pkg::t_div_req div_req_w, div_req_h;
    rog_pkg::t_div_rsp div_rsp_w, div_rsp_h;

    logic        in_fire, full, do_store, issue, hit, out_load, range_bad, ok_query;
    logic [31:0] add_x, add_y, add_w, add_h, add_side, unit_calc, half_unit;
    logic [47:0] px_prod, py_prod;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign full        = (r_count >= CNT_MAX);
    assign do_store    = in_fire && (i_in_data.op == rog_pkg::OP_ADD) && !full;

    // negative corners clamp to zero
    assign add_x    = i_in_data.rect_x[31] ? 32'd0 : i_in_data.rect_x;
    assign add_y    = i_in_data.rect_y[31] ? 32'd0 : i_in_data.rect_y;
    assign add_w    = {1'b0, i_in_data.rect_width};
    assign add_h    = {1'b0, i_in_data.rect_height};
    assign add_side = (add_w <= add_h) ? add_w : add_h;

    assign unit_calc = (r_count == '0) ? 32'd0 : {3'b000, r_prod[63:DIV10_SHIFT_L]};

    assign range_bad = (r_in.grid_col == 16'd0) || (r_in.grid_row == 16'd0) ||
                       (r_in.grid_col > 16'(r_cols)) || (r_in.grid_row > 16'(r_rows));

    assign px_prod = r_unit * r_in.grid_col;
    assign py_prod = r_unit * r_in.grid_row;

    assign issue = (r_state == S_SCAN) && (r_addr < r_count);
    assign hit   = r_rd_vld &&
                   ({16'd0, r_lo[63:32]} <= r_px) && (r_px <= {16'd0, r_up[63:32]}) &&
                   ({16'd0, r_lo[31:0]}  <= r_py) && (r_py <= {16'd0, r_up[31:0]});

    assign out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign ok_query  = (r_in.op == rog_pkg::OP_QUERY) && (r_status == rog_pkg::ST_OK);
    assign half_unit = r_unit >> 1;

    function automatic logic [GW-1:0] sat_count(input logic [31:0] q);
        logic [31:0] s;
        s = (q > GRID_CAP) ? GRID_CAP : q;
        return s[GW-1:0];
    endfunction

    // grid column and row counts in parallel
    assign div_req_w.start    = (r_state == S_DIVST) && (unit_calc != 32'd0);
    assign div_req_w.dividend = r_chip_w;
    assign div_req_w.divisor  = unit_calc;
    assign div_req_h.start    = div_req_w.start;
    assign div_req_h.dividend = r_chip_h;
    assign div_req_h.divisor  = unit_calc;

    rog_div u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req_w),
        .o_rsp   (div_rsp_w)
    );

    rog_div u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req_h),
        .o_rsp   (div_rsp_h)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_UNIT;
            end
            S_UNIT:  n_state = S_DIVST;
            S_DIVST: n_state = (unit_calc == 32'd0) ? S_CHECK : S_DIV;
            S_DIV: begin
                if (div_rsp_w.done) n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (r_in.op != rog_pkg::OP_QUERY) n_state = S_DONE;
                else if (r_unit == 32'd0)                  n_state = S_DONE;
                else if (range_bad)                        n_state = S_DONE;
                else                                       n_state = S_MUL;
            end
            S_MUL:  n_state = S_SCAN;
            S_SCAN: begin
                if (hit || (!issue && !r_rd_vld)) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chip_w    <= rog_pkg::CHIP_W_RESET;
            r_chip_h    <= rog_pkg::CHIP_H_RESET;
            r_count     <= '0;
            r_small     <= '1;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rog_pkg::REG_CHIP_WIDTH:  r_chip_w <= i_cfg_data;
                    rog_pkg::REG_CHIP_HEIGHT: r_chip_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire && (i_in_data.op == rog_pkg::OP_CLEAR)) begin
                r_count <= '0;
                r_small <= '1;
            end else if (do_store) begin
                r_count <= r_count + 1'b1;
                if (add_side < r_small) r_small <= add_side;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in     <= i_in_data;
            r_occ    <= 1'b0;
            r_status <= ((i_in_data.op == rog_pkg::OP_ADD) && full) ?
                        rog_pkg::ST_FULL : rog_pkg::ST_OK;
        end
        if (r_state == S_UNIT) r_prod <= r_small * rog_pkg::DIV10_MAGIC;
        if (r_state == S_DIVST) begin
            r_unit <= unit_calc;
            if (unit_calc == 32'd0) begin
                r_cols <= '0;
                r_rows <= '0;
            end
        end
        if ((r_state == S_DIV) && div_rsp_w.done) begin
            r_cols <= sat_count(div_rsp_w.quotient);
            r_rows <= sat_count(div_rsp_h.quotient);
        end
        if ((r_state == S_CHECK) && (r_in.op == rog_pkg::OP_QUERY)) begin
            if (r_unit == 32'd0)  r_status <= rog_pkg::ST_NO_UNIT;
            else if (range_bad)   r_status <= rog_pkg::ST_RANGE;
        end
        if (r_state == S_MUL) begin
            r_px   <= px_prod;
            r_py   <= py_prod;
            r_addr <= '0;
        end
        if (issue) r_addr <= r_addr + 1'b1;
        if ((r_state == S_SCAN) && hit) r_occ <= 1'b1;
        if (out_load) begin
            r_out.status       <= r_status;
            r_out.occupied     <= r_occ;
            r_out.cell_x       <= ok_query ? (r_px[31:0] - half_unit) : 32'd0;
            r_out.cell_y       <= ok_query ? (r_py[31:0] - half_unit) : 32'd0;
            r_out.unit_length  <= r_unit;
            r_out.grid_columns <= 16'(r_cols);
            r_out.grid_rows    <= 16'(r_rows);
        end
    end

    // rectangle store: lower and upper corners, one read port each
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            mem_lo[r_count[IDX_W-1:0]] <= {add_x, add_y};
            mem_up[r_count[IDX_W-1:0]] <= {add_x + add_w, add_y + add_h};
        end
        if (issue) begin
            r_lo <= mem_lo[r_addr[IDX_W-1:0]];
            r_up <= mem_up[r_addr[IDX_W-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("store count beyond capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_count))
        else $error("scan address past store count");

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_store |=> (r_count == $past(r_count) + 1'b1))
        else $error("add transfer did not bump the count");

    a_unit_needs_rects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHECK) && (r_unit != 32'd0)) |-> (r_count != '0))
        else $error("grid unit with empty store");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp_w.done == div_rsp_h.done)
        else $error("grid dividers out of step");

    a_occ_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.occupied) |-> (o_out_data.status == rog_pkg::ST_OK))
        else $error("occupied flagged on a failed op");

endmodule

`default_nettype wire

// ===== bench/rect_occupancy_grid_tb.sv =====
// Self-checking bench for rect_occupancy_grid: directed ops, then random bursts of
// clear / add / query and stray ops under several chip sizes and idle patterns, checked
// against a behavioural prediction. Depends on rog_pkg and the rect_occupancy_grid RTL.
`timescale 1ns / 1ps

module rect_occupancy_grid_tb;

    localparam int          MAX_RECTS = 128;
    localparam int          GRID_BITS = 16;
    localparam logic [31:0] GRID_CAP  = (GRID_BITS >= 16) ? 32'hFFFF
                                                           : (32'd1 << GRID_BITS) - 32'd1;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam int          SEG_ITEMS = 130;
    localparam int          LIMIT     = 1_000_000;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rog_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    rog_pkg::t_in_item             in_data   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    rog_pkg::t_out_item            out_data;

    rect_occupancy_grid DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- grid prediction ----------------
    logic [31:0] chip_w_q = rog_pkg::CHIP_W_RESET;
    logic [31:0] chip_h_q = rog_pkg::CHIP_H_RESET;
    logic [31:0] lo_x [MAX_RECTS];
    logic [31:0] lo_y [MAX_RECTS];
    logic [31:0] hi_x [MAX_RECTS];
    logic [31:0] hi_y [MAX_RECTS];
    int          n_rects  = 0;
    logic [31:0] min_side = '1;

    rog_pkg::t_in_item  pending_ops[$];
    rog_pkg::t_out_item grid_answers[$];

    int src_idle  = 34;
    int sink_idle = 46;
    int errors    = 0;
    int cycles    = 0;

    function automatic logic [15:0] cells_along(input logic [31:0] size,
                                                input logic [31:0] unit);
        logic [31:0] n;
        if (unit == 32'd0) return 16'd0;
        n = size / unit;
        if (n > GRID_CAP) n = GRID_CAP;
        return n[15:0];
    endfunction

    function automatic rog_pkg::t_out_item grid_step(input rog_pkg::t_in_item it);
        rog_pkg::t_out_item r;
        logic [31:0]        x, y, w, h, side, unit;
        logic [63:0]        px, py;
        r = '0;
        if (it.op == rog_pkg::OP_CLEAR) begin
            n_rects  = 0;
            min_side = '1;
        end else if (it.op == rog_pkg::OP_ADD) begin
            if (n_rects >= MAX_RECTS) begin
                r.status = rog_pkg::ST_FULL;
            end else begin
                x = it.rect_x[31] ? 32'd0 : it.rect_x;
                y = it.rect_y[31] ? 32'd0 : it.rect_y;
                w = {1'b0, it.rect_width};
                h = {1'b0, it.rect_height};
                side = (w <= h) ? w : h;
                lo_x[n_rects] = x;
                lo_y[n_rects] = y;
                hi_x[n_rects] = x + w;
                hi_y[n_rects] = y + h;
                n_rects++;
                if (side < min_side) min_side = side;
            end
        end
        unit = (n_rects == 0) ? 32'd0 : min_side / 32'd10;
        r.unit_length  = unit;
        r.grid_columns = cells_along(chip_w_q, unit);
        r.grid_rows    = cells_along(chip_h_q, unit);
        if (it.op == rog_pkg::OP_QUERY) begin
            if (unit == 32'd0) begin
                r.status = rog_pkg::ST_NO_UNIT;
            end else if (it.grid_col == 16'd0 || it.grid_row == 16'd0 ||
                         it.grid_col > r.grid_columns || it.grid_row > r.grid_rows) begin
                r.status = rog_pkg::ST_RANGE;
            end else begin
                px = 64'(unit) * 64'(it.grid_col);
                py = 64'(unit) * 64'(it.grid_row);
                for (int k = 0; k < n_rects; k++) begin
                    if (64'(lo_x[k]) <= px && px <= 64'(hi_x[k]) &&
                        64'(lo_y[k]) <= py && py <= 64'(hi_y[k]))
                        r.occupied = 1'b1;
                end
                r.cell_x = 32'(px - 64'(unit / 32'd2));
                r.cell_y = 32'(py - 64'(unit / 32'd2));
            end
        end
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) grid_answers = {grid_answers, grid_step(in_data)};  // transfer
            if (pending_ops.size() != 0 && $urandom_range(99) >= src_idle) begin
                in_data  <= pending_ops.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin : monitor
        rog_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (grid_answers.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: st=%0d occ=%0d cx=%h cy=%h",
                                 out_data.status, out_data.occupied,
                                 out_data.cell_x, out_data.cell_y);
                end else begin
                    want = grid_answers.pop_front();
                    if (out_data.status !== want.status ||
                        out_data.occupied !== want.occupied ||
                        out_data.cell_x !== want.cell_x ||
                        out_data.cell_y !== want.cell_y ||
                        out_data.unit_length !== want.unit_length ||
                        out_data.grid_columns !== want.grid_columns ||
                        out_data.grid_rows !== want.grid_rows) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch got : st=%0d occ=%0d cx=%h cy=%h u=%h c=%0d r=%0d",
                                     out_data.status, out_data.occupied, out_data.cell_x,
                                     out_data.cell_y, out_data.unit_length,
                                     out_data.grid_columns, out_data.grid_rows);
                            $display("         want: st=%0d occ=%0d cx=%h cy=%h u=%h c=%0d r=%0d",
                                     want.status, want.occupied, want.cell_x, want.cell_y,
                                     want.unit_length, want.grid_columns, want.grid_rows);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL rect_occupancy_grid");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // generator's own view of the store, running ahead of the block
    int          g_count = 0;
    logic [31:0] g_side  = '1;
    logic [31:0] g_lx, g_ly, g_w, g_h;
    int          made    = 0;

    task automatic push_item(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] col, input logic [31:0] row);
        rog_pkg::t_in_item it;
        logic [31:0]       side;
        it.op          = op;
        it.rect_x      = x;
        it.rect_y      = y;
        it.rect_width  = w[30:0];
        it.rect_height = h[30:0];
        it.grid_col    = col[15:0];
        it.grid_row    = row[15:0];
        if (op == rog_pkg::OP_CLEAR) begin
            g_count = 0;
            g_side  = '1;
        end else if (op == rog_pkg::OP_ADD && g_count < MAX_RECTS) begin
            g_lx = x[31] ? 32'd0 : x;
            g_ly = y[31] ? 32'd0 : y;
            g_w  = {1'b0, w[30:0]};
            g_h  = {1'b0, h[30:0]};
            side = (g_w <= g_h) ? g_w : g_h;
            if (side < g_side) g_side = side;
            g_count++;
        end
        pending_ops = {pending_ops, it};
        made++;
    endtask

    task automatic add_rect();
        logic [31:0] x, y, w, h, limx, limy;
        int          mode;
        limx = chip_w_q[31] ? 32'h7FFF_FFFF : chip_w_q;
        limy = chip_h_q[31] ? 32'h7FFF_FFFF : chip_h_q;
        mode = $urandom_range(99);
        w = $urandom_range(98304, 3277);
        h = $urandom_range(98304, 3277);
        x = $urandom_range(limx, 0);
        y = $urandom_range(limy, 0);
        if (mode < 4) begin
            // tiny side: no unit, or a unit of a few steps and a saturated grid
            w = $urandom_range(40, 0);
        end else if (mode < 14) begin
            x = ~$urandom_range(1000000, 0);
            if ($urandom_range(1) == 1) y = ~$urandom_range(1000000, 0);
        end else if (mode < 22) begin
            x = $urandom();
            y = $urandom();
            w = $urandom();
            h = $urandom();
        end
        push_item(rog_pkg::OP_ADD, x, y, w, h, $urandom(), $urandom());
    endtask

    function automatic logic [31:0] aim_index(input logic [31:0] lo, input logic [31:0] span,
                                              input logic [31:0] unit, input logic [15:0] lim);
        logic [31:0] room;
        logic [63:0] idx;
        room = (span > unit) ? span - unit : 32'd0;
        idx  = (64'(lo) + 64'($urandom_range(room, 0))) / 64'(unit) + 64'd1;
        if (idx > 64'(lim)) idx = 64'(lim);
        return idx[31:0];
    endfunction

    task automatic query_item();
        logic [31:0] unit, c, r, bad;
        logic [15:0] cols, rows;
        int          mode;
        unit = (g_count == 0) ? 32'd0 : g_side / 32'd10;
        cols = cells_along(chip_w_q, unit);
        rows = cells_along(chip_h_q, unit);
        mode = $urandom_range(99);
        if (unit == 32'd0 || cols == 16'd0 || rows == 16'd0) begin
            c = $urandom();
            r = $urandom();
        end else begin
            if (mode < 55) begin
                c = aim_index(g_lx, g_w, unit, cols);
                r = aim_index(g_ly, g_h, unit, rows);
            end else begin
                c = $urandom_range(32'(cols), 1);
                r = $urandom_range(32'(rows), 1);
            end
            case ($urandom_range(2))
                0:       bad = 32'd0;
                1:       bad = 32'(cols) + 32'd1;
                default: bad = $urandom();
            endcase
            if (mode >= 88 && mode < 94) c = bad;
            else if (mode >= 94) r = (bad == 32'(cols) + 32'd1) ? 32'(rows) + 32'd1 : bad;
        end
        push_item(rog_pkg::OP_QUERY, $urandom(), $urandom(), $urandom(), $urandom(), c, r);
    endtask

    task automatic add_burst(input bit fill);
        int n_add;
        if (!fill && $urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1))
                push_item(2'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
            return;
        end
        if (fill || $urandom_range(2) == 0)
            push_item(rog_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom());
        n_add = (fill || $urandom_range(29) == 0) ? $urandom_range(134, 128)
                                                  : $urandom_range(8, 1);
        repeat (n_add) add_rect();
        repeat ($urandom_range(10, 1)) query_item();
    endtask

    task automatic write_reg(input logic [rog_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rog_pkg::REG_CHIP_WIDTH) chip_w_q = val;
        else chip_h_q = val;
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || in_valid || grid_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        logic [31:0] cw, ch;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset chip size 4.0 x 3.0 mm
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 1, 1);     // empty store
        push_item(OP_UNUSED, '1, '1, '1, '1, '1, '1);
        push_item(rog_pkg::OP_ADD, 0, 0, 65536, 65536, '0, '0); // unit 6553, 40 x 30 grid
        push_item(rog_pkg::OP_QUERY, '1, '1, '1, '1, 1, 1);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 40, 30);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 0, 1);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 41, 1);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 1, 31);
        push_item(rog_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 40, 30);
        // side zero
        push_item(rog_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 5, '1, '1);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 1, 1);
        push_item(rog_pkg::OP_CLEAR, '1, '1, '1, '1, '1, '1);
        push_item(rog_pkg::OP_ADD, 100, 100, 10, 10, 0, 0);     // unit 1, grid saturates
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 65535, 65535);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 105, 110); // on upper bound
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 111, 105);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 100, 100); // on lower bound
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 99, 100);
        push_item(rog_pkg::OP_ADD, 0, 0, 9, 1000, 0, 0);        // side below ten steps
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 1, 1);
        push_item(rog_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0);
        push_item(rog_pkg::OP_QUERY, '0, '0, '0, '0, 1, 1);

        for (int seg = 0; seg < 6; seg++) begin
            drain();
            case (seg)
                0:       begin cw = rog_pkg::CHIP_W_RESET; ch = rog_pkg::CHIP_H_RESET; end
                1:       begin cw = 32'd0;        ch = 32'hFFFF_FFFF; end
                2:       begin cw = 32'hFFFF_FFFF; ch = 32'd0; end
                3:       begin cw = $urandom_range(32'h00FF_FFFF, 1);
                               ch = $urandom_range(32'h00FF_FFFF, 1); end
                4:       begin cw = 32'hFFFF_FFFF; ch = 32'hFFFF_FFFF; end
                default: begin cw = $urandom_range(32'h0040_0000, 32'h0001_0000);
                               ch = $urandom_range(32'h0040_0000, 32'h0001_0000); end
            endcase
            write_reg(rog_pkg::REG_CHIP_WIDTH, cw);
            write_reg(rog_pkg::REG_CHIP_HEIGHT, ch);
            if (seg < 2) begin
                src_idle = 34; sink_idle = 46;
            end else if (seg < 4) begin
                src_idle = 46; sink_idle = 34;
            end else begin
                src_idle = 0; sink_idle = 0;
            end
            made = 0;
            while (made < SEG_ITEMS) add_burst(seg == 0 && made == 0);
        end

        drain();
        repeat (60) @(posedge clk);
        if (errors == 0 && grid_answers.size() == 0) begin
            $display("PASS rect_occupancy_grid");
        end else begin
            $display("FAIL rect_occupancy_grid");
        end
        $finish;
    end

endmodule
